>>> sv/srdp_pkg.sv
// srdp_pkg: shared constants, types and helpers of the sensor reply decimal parser.
// No dependencies; compiled first.
package srdp_pkg;

  localparam int STRING_BYTES = 31;
  localparam int CNT_W        = $clog2(STRING_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(STRING_BYTES);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_TYPE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SUCCESS_CODE = 1'b1;

  localparam logic [2:0] SENSOR_PH       = 3'd0;
  localparam logic [2:0] SENSOR_EC       = 3'd1;
  localparam logic [2:0] SENSOR_ORP      = 3'd2;
  localparam logic [2:0] SENSOR_DO       = 3'd3;
  localparam logic [2:0] SENSOR_RTD      = 3'd4;
  localparam logic [2:0] SENSOR_TYPE_MAX = SENSOR_RTD;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_CODE = 2'd1;
  localparam logic [1:0] STAT_BAD_TYPE = 2'd2;

  localparam logic [2:0] FIELD_READING  = 3'd0;
  localparam logic [2:0] FIELD_TDS      = 3'd1;
  localparam logic [2:0] FIELD_SALINITY = 3'd2;
  localparam logic [2:0] FIELD_GRAVITY  = 3'd3;
  localparam logic [2:0] FIELD_LAST     = 3'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] FRAC_DIGITS = 2'd3;

  // floor(2^SH / D): quotient estimate is exact or one low
  localparam logic [31:0] RECIP_1000    = 32'd2199023255;
  localparam int          RECIP_1000_SH = 41;
  localparam logic [31:0] RECIP_10      = 32'd3435973836;
  localparam int          RECIP_10_SH   = 35;
  localparam logic [31:0] DIVISOR_1000  = 32'd1000;
  localparam logic [31:0] DIVISOR_10    = 32'd10;

  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_1000,
    DIV_10
  } div_sel_t;

  typedef struct packed {
    logic [31:0] int_acc;
    logic [9:0]  frac_acc;
    logic [1:0]  frac_count;
    logic        neg;
  } srdp_acc_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] status;
    logic       close1;
    logic       close2;
    logic [2:0] stype;
    logic [2:0] idx1;
    logic [2:0] idx2;
  } srdp_ctl_t;

  function automatic logic [31:0] mul10(input logic [31:0] x);
    return (x << 3) + (x << 1);
  endfunction

  function automatic logic [31:0] mul1000(input logic [31:0] x);
    return (x << 10) - (x << 4) - (x << 3);
  endfunction

endpackage

>>> sv/srdp_in_if.sv
// srdp_in_if: byte channel into the parser, valid/ready handshake.
// Depends on nothing.
interface srdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_start, output frame_end,
                  input ready);
  modport sink   (input valid, input data_byte, input frame_start, input frame_end,
                  output ready);
endinterface

>>> sv/srdp_out_if.sv
// srdp_out_if: result channel of the parser, valid/ready handshake.
// Depends on nothing.
interface srdp_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] reading;
  logic signed [31:0] tds;
  logic signed [31:0] salinity;
  logic signed [31:0] gravity;

  modport source (output valid, output status, output reading, output tds,
                  output salinity, output gravity, input ready);
  modport sink   (input valid, input status, input reading, input tds,
                  input salinity, input gravity, output ready);
endinterface

>>> sv/sensor_reply_decimal_parser.sv
// sensor_reply_decimal_parser: top level; configuration registers, parser and scaler.
// Depends on srdp_pkg, srdp_in_if, srdp_out_if, srdp_parser and srdp_scale.
//
// Takes one reply byte per clock and gives one result per frame end. Each byte
// updates the field parser in the cycle it is transferred; field closes then flow
// through a four-stage pipeline (value, 32x32 reciprocal multiply, quotient
// correction, held values and result register) behind the field-close snapshot
// register. The parser state update sets the rate of one byte per cycle. Input
// is held off only while a result waits at the output and the pipeline behind
// it is full. Write configuration only when no frame is in flight.
module sensor_reply_decimal_parser import srdp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  srdp_in_if.sink               in_ch,
  srdp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [2:0] sensor_type_r, sensor_type_nxt;
  logic [7:0] success_code_r, success_code_nxt;
  logic       s2_take, s1_vld;
  srdp_ctl_t  s1_ctl;
  srdp_acc_t  s1_acc;

  always_comb begin
    sensor_type_nxt  = sensor_type_r;
    success_code_nxt = success_code_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SENSOR_TYPE:  sensor_type_nxt  = cfg_wdata[2:0];
        REG_SUCCESS_CODE: success_code_nxt = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_type_r  <= SENSOR_PH;
      success_code_r <= 8'd1;
    end else begin
      sensor_type_r  <= sensor_type_nxt;
      success_code_r <= success_code_nxt;
    end
  end

  srdp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .sensor_type  (sensor_type_r),
    .success_code (success_code_r),
    .s2_take      (s2_take),
    .s1_vld       (s1_vld),
    .s1_ctl       (s1_ctl),
    .s1_acc       (s1_acc)
  );

  srdp_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1_vld  (s1_vld),
    .s1_ctl  (s1_ctl),
    .s1_acc  (s1_acc),
    .s2_take (s2_take),
    .out_ch  (out_ch)
  );

  // input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without a blocked result");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != STAT_OK |->
      out_ch.reading == 32'sd0 && out_ch.tds == 32'sd0 &&
      out_ch.salinity == 32'sd0 && out_ch.gravity == 32'sd0)
    else $error("error result carries nonzero values");

endmodule

>>> sv/srdp_parser.sv
// srdp_parser: per-byte field parser state and the field-close snapshot register.
// Depends on srdp_pkg and srdp_in_if.
module srdp_parser import srdp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  srdp_in_if.sink    in_ch,
  input  logic [2:0] sensor_type,
  input  logic [7:0] success_code,
  input  logic       s2_take,
  output logic       s1_vld,
  output srdp_ctl_t  s1_ctl,
  output srdp_acc_t  s1_acc
);

  logic             code_ok_r, code_ok_mid, code_ok_nxt;
  logic             done_r, done_mid, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_mid, cnt_nxt;
  logic [2:0]       fidx_r, fidx_mid, fidx_nxt;
  srdp_acc_t        acc_r, acc_mid, acc_nxt;
  logic             lead_r, lead_mid, lead_nxt;
  logic             frac_r, frac_mid, frac_nxt;
  logic             stop_r, stop_mid, stop_nxt;

  logic       s1_vld_r;
  srdp_ctl_t  s1_ctl_r, s1_ctl_nxt;
  srdp_acc_t  s1_acc_r, s1_acc_nxt;
  logic       s1_take, in_fire, comma;
  logic [7:0] b;
  logic [3:0] digit;
  logic [1:0] status;

  assign s1_take     = !s1_vld_r || s2_take;
  assign in_ch.ready = s1_take;
  assign in_fire     = in_ch.valid && s1_take;
  assign b           = in_ch.data_byte;
  assign digit       = 4'(b - CH_ZERO);

  always_comb begin
    code_ok_mid = code_ok_r;
    done_mid    = done_r;
    cnt_mid     = cnt_r;
    fidx_mid    = fidx_r;
    acc_mid     = acc_r;
    lead_mid    = lead_r;
    frac_mid    = frac_r;
    stop_mid    = stop_r;
    comma       = 1'b0;
    if (in_ch.frame_start) begin
      code_ok_mid = (b == success_code);
      done_mid    = 1'b0;
      cnt_mid     = '0;
      fidx_mid    = FIELD_READING;
      acc_mid     = '0;
      lead_mid    = 1'b1;
      frac_mid    = 1'b0;
      stop_mid    = 1'b0;
    end else if (code_ok_r && !done_r) begin
      if (cnt_r >= CNT_LIMIT || b == CH_NUL) begin
        done_mid = 1'b1;
      end else begin
        cnt_mid = cnt_r + CNT_W'(1);
        if (b == CH_COMMA) begin
          comma    = 1'b1;
          fidx_mid = (fidx_r == FIELD_LAST) ? fidx_r : fidx_r + 3'd1;
          acc_mid  = '0;
          lead_mid = 1'b1;
          frac_mid = 1'b0;
          stop_mid = 1'b0;
        end else if (!stop_r) begin
          if (lead_r && b == CH_SPACE) begin
            lead_mid = 1'b1;
          end else if (lead_r && b == CH_MINUS) begin
            lead_mid    = 1'b0;
            acc_mid.neg = 1'b1;
          end else begin
            lead_mid = 1'b0;
            if (b == CH_DOT) begin
              frac_mid = 1'b1;
            end else if (b inside {[CH_ZERO:CH_NINE]}) begin
              if (frac_r) begin
                if (acc_r.frac_count != FRAC_DIGITS) begin
                  acc_mid.frac_acc   = 10'(mul10({22'b0, acc_r.frac_acc})) + 10'(digit);
                  acc_mid.frac_count = acc_r.frac_count + 2'd1;
                end
              end else begin
                acc_mid.int_acc = mul10(acc_r.int_acc) + {28'b0, digit};
              end
            end else if (b == CH_CR || b == CH_LF) begin
              stop_mid = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    if (!code_ok_mid) begin
      status = STAT_BAD_CODE;
    end else if (sensor_type > SENSOR_TYPE_MAX) begin
      status = STAT_BAD_TYPE;
    end else begin
      status = STAT_OK;
    end
    s1_ctl_nxt.emit   = in_ch.frame_end;
    s1_ctl_nxt.status = status;
    s1_ctl_nxt.close1 = comma || (in_ch.frame_end && status == STAT_OK);
    s1_ctl_nxt.close2 = comma && in_ch.frame_end && status == STAT_OK;
    s1_ctl_nxt.stype  = sensor_type;
    s1_ctl_nxt.idx1   = comma ? fidx_r : fidx_mid;
    s1_ctl_nxt.idx2   = fidx_mid;
    s1_acc_nxt        = comma ? acc_r : acc_mid;
  end

  always_comb begin
    code_ok_nxt = code_ok_r;
    done_nxt    = done_r;
    cnt_nxt     = cnt_r;
    fidx_nxt    = fidx_r;
    acc_nxt     = acc_r;
    lead_nxt    = lead_r;
    frac_nxt    = frac_r;
    stop_nxt    = stop_r;
    if (in_fire) begin
      if (in_ch.frame_end) begin
        code_ok_nxt = 1'b0;
        done_nxt    = 1'b0;
        cnt_nxt     = '0;
        fidx_nxt    = FIELD_READING;
        acc_nxt     = '0;
        lead_nxt    = 1'b1;
        frac_nxt    = 1'b0;
        stop_nxt    = 1'b0;
      end else begin
        code_ok_nxt = code_ok_mid;
        done_nxt    = done_mid;
        cnt_nxt     = cnt_mid;
        fidx_nxt    = fidx_mid;
        acc_nxt     = acc_mid;
        lead_nxt    = lead_mid;
        frac_nxt    = frac_mid;
        stop_nxt    = stop_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_ok_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
      fidx_r    <= FIELD_READING;
      acc_r     <= '0;
      lead_r    <= 1'b1;
      frac_r    <= 1'b0;
      stop_r    <= 1'b0;
      s1_vld_r  <= 1'b0;
    end else begin
      code_ok_r <= code_ok_nxt;
      done_r    <= done_nxt;
      cnt_r     <= cnt_nxt;
      fidx_r    <= fidx_nxt;
      acc_r     <= acc_nxt;
      lead_r    <= lead_nxt;
      frac_r    <= frac_nxt;
      stop_r    <= stop_nxt;
      if (s1_take) begin
        s1_vld_r <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_ctl_r <= s1_ctl_nxt;
      s1_acc_r <= s1_acc_nxt;
    end
  end

  assign s1_vld = s1_vld_r;
  assign s1_ctl = s1_ctl_r;
  assign s1_acc = s1_acc_r;

endmodule

>>> sv/srdp_scale.sv
// srdp_scale: field value, constant division pipeline, held values and result register.
// Depends on srdp_pkg and srdp_out_if.
module srdp_scale import srdp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s1_vld,
  input  srdp_ctl_t  s1_ctl,
  input  srdp_acc_t  s1_acc,
  output logic       s2_take,
  srdp_out_if.source out_ch
);

  logic        s2_vld_r;
  srdp_ctl_t   s2_ctl_r;
  logic [31:0] s2_v_r, s2_v_nxt;

  logic        s3_vld_r;
  srdp_ctl_t   s3_ctl_r;
  div_sel_t    s3_sel_r, s3_sel_nxt;
  logic [31:0] s3_v_r, s3_mag_r, s3_mag_nxt;
  logic [63:0] s3_prod_r, s3_prod_nxt;

  logic        s4_vld_r;
  srdp_ctl_t   s4_ctl_r;
  div_sel_t    s4_sel_r;
  logic [31:0] s4_v_r, s4_q_r, s4_q_nxt;

  logic [31:0] held_reading_r, held_reading_nxt;
  logic [31:0] held_tds_r, held_tds_nxt;
  logic [31:0] held_salinity_r, held_salinity_nxt;
  logic [31:0] held_gravity_r, held_gravity_nxt;

  logic        out_vld_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_reading_r, out_tds_r, out_salinity_r, out_gravity_r;

  logic        out_free, s4_go, s4_take, s3_take;
  logic [31:0] fz, fpad, x, recip, q0, qd, rem, divisor, scaled;
  logic        is_ec_out;

  assign out_free = !out_vld_r || out_ch.ready;
  assign s4_go    = s4_vld_r && (!s4_ctl_r.emit || out_free);
  assign s4_take  = !s4_vld_r || s4_go;
  assign s3_take  = !s3_vld_r || s4_take;
  assign s2_take  = !s2_vld_r || s3_take;

  // field value: int * 1000 + padded fraction, sign applied
  always_comb begin
    fz = {22'b0, s1_acc.frac_acc};
    case (s1_acc.frac_count)
      2'd0:    fpad = mul1000(fz);
      2'd1:    fpad = mul10(mul10(fz));
      2'd2:    fpad = mul10(fz);
      default: fpad = fz;
    endcase
    x        = mul1000(s1_acc.int_acc) + fpad;
    s2_v_nxt = s1_acc.neg ? 32'd0 - x : x;
  end

  // divisor select and reciprocal multiply
  always_comb begin
    s3_sel_nxt = DIV_NONE;
    if (s2_ctl_r.idx1 == FIELD_READING) begin
      if (s2_ctl_r.stype == SENSOR_EC || s2_ctl_r.stype == SENSOR_ORP) begin
        s3_sel_nxt = DIV_1000;
      end else if (s2_ctl_r.stype == SENSOR_DO || s2_ctl_r.stype == SENSOR_RTD) begin
        s3_sel_nxt = DIV_10;
      end
    end else if (s2_ctl_r.stype == SENSOR_EC) begin
      if (s2_ctl_r.idx1 == FIELD_TDS) begin
        s3_sel_nxt = DIV_1000;
      end else if (s2_ctl_r.idx1 == FIELD_SALINITY) begin
        s3_sel_nxt = DIV_10;
      end
    end
    s3_mag_nxt  = s2_v_r[31] ? 32'd0 - s2_v_r : s2_v_r;
    recip       = (s3_sel_nxt == DIV_10) ? RECIP_10 : RECIP_1000;
    s3_prod_nxt = {32'b0, s3_mag_nxt} * {32'b0, recip};
  end

  // quotient estimate is exact or one low
  always_comb begin
    if (s3_sel_r == DIV_10) begin
      q0      = 32'(s3_prod_r >> RECIP_10_SH);
      qd      = mul10(q0);
      divisor = DIVISOR_10;
    end else begin
      q0      = 32'(s3_prod_r >> RECIP_1000_SH);
      qd      = mul1000(q0);
      divisor = DIVISOR_1000;
    end
    rem      = s3_mag_r - qd;
    s4_q_nxt = (rem >= divisor) ? q0 + 32'd1 : q0;
  end

  always_comb begin
    scaled = (s4_sel_r == DIV_NONE) ? s4_v_r :
             (s4_v_r[31] ? 32'd0 - s4_q_r : s4_q_r);
    held_reading_nxt  = held_reading_r;
    held_tds_nxt      = held_tds_r;
    held_salinity_nxt = held_salinity_r;
    held_gravity_nxt  = held_gravity_r;
    if (s4_go && s4_ctl_r.close1 && s4_ctl_r.stype <= SENSOR_TYPE_MAX) begin
      if (s4_ctl_r.idx1 == FIELD_READING) begin
        held_reading_nxt = scaled;
      end else if (s4_ctl_r.stype == SENSOR_EC) begin
        case (s4_ctl_r.idx1)
          FIELD_TDS:      held_tds_nxt      = scaled;
          FIELD_SALINITY: held_salinity_nxt = scaled;
          FIELD_GRAVITY:  held_gravity_nxt  = scaled;
          default: ;
        endcase
      end
    end
    // empty field closed at frame end right after a comma
    if (s4_go && s4_ctl_r.close2 && s4_ctl_r.stype <= SENSOR_TYPE_MAX) begin
      if (s4_ctl_r.idx2 == FIELD_READING) begin
        held_reading_nxt = 32'd0;
      end else if (s4_ctl_r.stype == SENSOR_EC) begin
        case (s4_ctl_r.idx2)
          FIELD_TDS:      held_tds_nxt      = 32'd0;
          FIELD_SALINITY: held_salinity_nxt = 32'd0;
          FIELD_GRAVITY:  held_gravity_nxt  = 32'd0;
          default: ;
        endcase
      end
    end
    is_ec_out = (s4_ctl_r.status == STAT_OK) && (s4_ctl_r.stype == SENSOR_EC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r        <= 1'b0;
      s3_vld_r        <= 1'b0;
      s4_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
      held_reading_r  <= '0;
      held_tds_r      <= '0;
      held_salinity_r <= '0;
      held_gravity_r  <= '0;
    end else begin
      if (s2_take) begin
        s2_vld_r <= s1_vld;
      end
      if (s3_take) begin
        s3_vld_r <= s2_vld_r;
      end
      if (s4_take) begin
        s4_vld_r <= s3_vld_r;
      end
      if (s4_go && s4_ctl_r.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      held_reading_r  <= held_reading_nxt;
      held_tds_r      <= held_tds_nxt;
      held_salinity_r <= held_salinity_nxt;
      held_gravity_r  <= held_gravity_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_ctl_r <= s1_ctl;
      s2_v_r   <= s2_v_nxt;
    end
    if (s3_take) begin
      s3_ctl_r  <= s2_ctl_r;
      s3_sel_r  <= s3_sel_nxt;
      s3_v_r    <= s2_v_r;
      s3_mag_r  <= s3_mag_nxt;
      s3_prod_r <= s3_prod_nxt;
    end
    if (s4_take) begin
      s4_ctl_r <= s3_ctl_r;
      s4_sel_r <= s3_sel_r;
      s4_v_r   <= s3_v_r;
      s4_q_r   <= s4_q_nxt;
    end
    if (s4_go && s4_ctl_r.emit) begin
      out_status_r   <= s4_ctl_r.status;
      out_reading_r  <= (s4_ctl_r.status == STAT_OK) ? held_reading_nxt : 32'd0;
      out_tds_r      <= is_ec_out ? held_tds_nxt : 32'd0;
      out_salinity_r <= is_ec_out ? held_salinity_nxt : 32'd0;
      out_gravity_r  <= is_ec_out ? held_gravity_nxt : 32'd0;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.reading  = $signed(out_reading_r);
  assign out_ch.tds      = $signed(out_tds_r);
  assign out_ch.salinity = $signed(out_salinity_r);
  assign out_ch.gravity  = $signed(out_gravity_r);

endmodule

>>> tb/sv/srdp_reply_checker.sv
`timescale 1ns / 1ps
// srdp_reply_checker: watches the byte and result channels of the reply parser,
// predicts each result from the transferred bytes and register writes, and compares.
// Depends on srdp_pkg, srdp_in_if and srdp_out_if.
module srdp_reply_checker import srdp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  srdp_in_if                    in_mon,
  srdp_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    awaited
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] reading;
    logic [31:0] tds;
    logic [31:0] salinity;
    logic [31:0] gravity;
  } reply_result_t;

  reply_result_t expected_replies[$];

  logic [2:0]  sensor_kind;
  logic [7:0]  good_code;

  logic        frame_ok;
  logic        text_closed;
  logic [4:0]  text_len;
  logic [2:0]  field_no;
  logic [31:0] whole_part;
  logic [9:0]  frac_part;
  logic [1:0]  frac_len;
  logic        minus_seen;
  logic        skipping_lead;
  logic        after_point;
  logic        number_halted;
  logic [31:0] held_reading;
  logic [31:0] held_tds;
  logic [31:0] held_salinity;
  logic [31:0] held_gravity;

  function automatic void reset_field();
    whole_part    = '0;
    frac_part     = '0;
    frac_len      = '0;
    minus_seen    = 1'b0;
    skipping_lead = 1'b1;
    after_point   = 1'b0;
    number_halted = 1'b0;
  endfunction

  function automatic void reset_frame();
    frame_ok    = 1'b0;
    text_closed = 1'b0;
    text_len    = '0;
    field_no    = FIELD_READING;
    reset_field();
  endfunction

  function automatic logic [31:0] div_toward_zero(input logic [31:0] v, input logic [31:0] d);
    int s;
    s = int'(v);
    return 32'(s / int'(d));
  endfunction

  // int*1000 + frac padded to three digits, wrapping, then sign
  function automatic logic [31:0] fixed_field_value();
    logic [31:0] f;
    logic [31:0] v;
    f = 32'(frac_part);
    for (int c = int'(frac_len); c < int'(FRAC_DIGITS); c++)
      f = f * 32'd10;
    v = whole_part * 32'd1000 + f;
    return minus_seen ? 32'd0 - v : v;
  endfunction

  function automatic void close_field();
    logic [31:0] v;
    v = fixed_field_value();
    if (sensor_kind <= SENSOR_TYPE_MAX) begin
      if (field_no == FIELD_READING) begin
        case (sensor_kind)
          SENSOR_PH:             held_reading = v;
          SENSOR_EC, SENSOR_ORP: held_reading = div_toward_zero(v, DIVISOR_1000);
          default:               held_reading = div_toward_zero(v, DIVISOR_10);
        endcase
      end else if (sensor_kind == SENSOR_EC) begin
        if (field_no == FIELD_TDS)
          held_tds = div_toward_zero(v, DIVISOR_1000);
        else if (field_no == FIELD_SALINITY)
          held_salinity = div_toward_zero(v, DIVISOR_10);
        else if (field_no == FIELD_GRAVITY)
          held_gravity = v;
      end
    end
    if (field_no < FIELD_LAST)
      field_no = field_no + 3'd1;
  endfunction

  function automatic void take_text_byte(input logic [7:0] b);
    if (!frame_ok || text_closed)
      return;
    if (text_len >= STRING_BYTES || b == CH_NUL) begin
      text_closed = 1'b1;
      return;
    end
    text_len = text_len + 5'd1;
    if (b == CH_COMMA) begin
      close_field();
      reset_field();
      return;
    end
    if (number_halted)
      return;
    if (skipping_lead) begin
      if (b == CH_SPACE)
        return;
      skipping_lead = 1'b0;
      if (b == CH_MINUS) begin
        minus_seen = 1'b1;
        return;
      end
    end
    if (b == CH_DOT) begin
      after_point = 1'b1;
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      if (after_point) begin
        if (frac_len < FRAC_DIGITS) begin
          frac_part = frac_part * 10'd10 + 10'(b - CH_ZERO);
          frac_len  = frac_len + 2'd1;
        end
      end else begin
        whole_part = whole_part * 32'd10 + 32'(b - CH_ZERO);
      end
    end else if (b == CH_CR || b == CH_LF) begin
      number_halted = 1'b1;
    end
  endfunction

  function automatic void take_reply_byte(input logic [7:0] b, input logic s, input logic e);
    reply_result_t r;
    if (s) begin
      reset_frame();
      frame_ok = (b == good_code);
    end else begin
      take_text_byte(b);
    end
    if (e) begin
      r = '0;
      if (!frame_ok) begin
        r.status = STAT_BAD_CODE;
      end else if (sensor_kind > SENSOR_TYPE_MAX) begin
        r.status = STAT_BAD_TYPE;
      end else begin
        close_field();
        r.status  = STAT_OK;
        r.reading = held_reading;
        if (sensor_kind == SENSOR_EC) begin
          r.tds      = held_tds;
          r.salinity = held_salinity;
          r.gravity  = held_gravity;
        end
      end
      expected_replies.push_back(r);
      reset_frame();
    end
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what,
               $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    reply_result_t want;
    if (!rst_n) begin
      sensor_kind   = SENSOR_PH;
      good_code     = 8'd1;
      held_reading  = '0;
      held_tds      = '0;
      held_salinity = '0;
      held_gravity  = '0;
      reset_frame();
      expected_replies.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result: status %0d reading %0d", $time,
                   out_mon.status, out_mon.reading);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 32'(want.status), 32'(out_mon.status));
          check_field("reading", want.reading, out_mon.reading);
          check_field("tds", want.tds, out_mon.tds);
          check_field("salinity", want.salinity, out_mon.salinity);
          check_field("gravity", want.gravity, out_mon.gravity);
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        take_reply_byte(in_mon.data_byte, in_mon.frame_start, in_mon.frame_end);
      // a register write takes effect after the transfer at the same edge
      if (cfg_we === 1'b1) begin
        if (cfg_index == REG_SENSOR_TYPE)
          sensor_kind = cfg_wdata[2:0];
        else if (cfg_index == REG_SUCCESS_CODE)
          good_code = cfg_wdata;
      end
    end
    awaited <= expected_replies.size();
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: clock, reset, reply-frame stimulus and register writes for the parser;
// the verdict comes from the mismatch and awaited-result counts of srdp_reply_checker.
// Depends on srdp_pkg, srdp_in_if, srdp_out_if, the parser RTL and srdp_reply_checker.
module testbench;
  import srdp_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int NUM_PHASES      = 8;
  localparam int PHASE_BYTES     = 185;

  typedef logic [7:0] byte_q_t[$];

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    awaited;
  int                    items_sent;
  int                    hold_requests;
  int                    cycle_count;
  bit                    tx_steady;
  logic [7:0]            cur_code;

  srdp_in_if  in_ch();
  srdp_out_if out_ch();

  sensor_reply_decimal_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  srdp_reply_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // mostly none, often short, rarely long
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  // result side: random stalls, ready runs, and long hold-offs on request
  initial begin : result_sink
    int run_left;
    int stall_left;
    int holds_done;
    out_ch.ready = 1'b0;
    run_left     = 0;
    stall_left   = 0;
    holds_done   = 0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        stall_left = HOLD_OFF_CYCLES;
        run_left   = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = ($urandom_range(0, 99) < 15) ? $urandom_range(50, 300)
                                                     : $urandom_range(0, 8);
          stall_left = gap_length();
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s, input logic e);
    int gap;
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.frame_start <= s;
    in_ch.frame_end   <= e;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    gap = tx_steady ? 0 : gap_length();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], 1'b0, 1'b0);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // waits out every awaited result plus fields still in the pipeline
  task automatic drain();
    go_quiet();
    do @(posedge clk); while (awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic byte_q_t number_field();
    byte_q_t q;
    int n;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) q.push_back(CH_SPACE);
    if ($urandom_range(0, 2) == 0)
      q.push_back(CH_MINUS);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
    repeat (n) q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 3) != 0) begin
      q.push_back(CH_DOT);
      repeat ($urandom_range(0, 5)) q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 5) == 0) begin
      q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
      repeat ($urandom_range(0, 2)) q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 9) == 0)
      q.insert($urandom_range(0, q.size()), 8'($urandom));
    return q;
  endfunction

  task automatic random_reply(input bit may_break);
    byte_q_t text;
    byte_q_t part;
    logic [7:0] status_byte;
    int fields;
    int n;
    bit abandon;
    if (may_break && $urandom_range(0, 19) == 0)
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom), 1'b0, $urandom_range(0, 3) == 0);
    status_byte = ($urandom_range(0, 9) < 8) ? cur_code : 8'($urandom);
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 40)) text.push_back(8'($urandom));
    end else begin
      fields = $urandom_range(1, 6);
      for (int i = 0; i < fields; i++) begin
        part = number_field();
        text = {text, part};
        if (i != fields - 1)
          text.push_back(CH_COMMA);
      end
      case ($urandom_range(0, 7))
        0: text.push_back(CH_NUL);
        1: begin
          text.push_back(CH_NUL);
          repeat ($urandom_range(1, 4)) text.push_back(8'($urandom));
        end
        2: repeat ($urandom_range(10, 30)) text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        default: ;
      endcase
    end
    tx_steady = ($urandom_range(0, 4) == 0);
    n = text.size();
    abandon = may_break && $urandom_range(0, 11) == 0;
    if (abandon)
      n = $urandom_range(0, n);
    send_byte(status_byte, 1'b1, !abandon && n == 0);
    for (int i = 0; i < n; i++)
      send_byte(text[i], 1'b0, !abandon && i == n - 1);
  endtask

  initial begin : stimulus
    logic [2:0] phase_type [NUM_PHASES];
    logic [7:0] phase_code [NUM_PHASES];
    int target;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.frame_start = 1'b0;
    in_ch.frame_end   = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    tx_steady         = 1'b0;
    items_sent        = 0;
    hold_requests     = 0;
    cur_code          = 8'd1;
    phase_type = '{SENSOR_EC, SENSOR_PH, SENSOR_ORP, SENSOR_DO, SENSOR_RTD, 3'b111,
                   3'($urandom_range(SENSOR_TYPE_MAX + 1, 6)), SENSOR_EC};
    phase_code = '{8'd1, 8'd0, 8'hFF, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'hFF};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: pH, success code 1
    send_byte(8'h41, 1'b0, 1'b1);
    send_byte(8'h01, 1'b1, 1'b1);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    drain();
    write_reg(REG_SENSOR_TYPE, CFG_DATA_W'(SENSOR_EC));
    // three EC fields: gravity keeps its old value, CR stops the salinity number
    send_byte(8'h01, 1'b1, 1'b0);
    send_text(" -7.5,8000,9\r5");
    send_byte(CH_NUL, 1'b0, 1'b1);
    send_byte(8'h02, 1'b1, 1'b0);
    send_byte(8'h35, 1'b0, 1'b1);
    drain();
    write_reg(REG_SENSOR_TYPE, CFG_DATA_W'(3'b111));
    send_byte(8'h01, 1'b1, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(REG_SENSOR_TYPE, CFG_DATA_W'(phase_type[p]));
      write_reg(REG_SUCCESS_CODE, phase_code[p]);
      cur_code = phase_code[p];
      if (p == 1) begin
        // result side holds off while short frames keep coming
        hold_requests++;
        tx_steady = 1'b1;
        repeat (40) begin
          if ($urandom_range(0, 1) == 0) begin
            send_byte(cur_code, 1'b1, 1'b1);
          end else begin
            send_byte(cur_code, 1'b1, 1'b0);
            send_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0, 1'b1);
          end
        end
      end
      target = items_sent + PHASE_BYTES;
      while (items_sent < target)
        random_reply(1'b1);
      random_reply(1'b0);
    end

    drain();
    if (mismatches == 0 && awaited == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
sv/srdp_pkg.sv
sv/srdp_in_if.sv
sv/srdp_out_if.sv
sv/srdp_parser.sv
sv/srdp_scale.sv
sv/sensor_reply_decimal_parser.sv
tb/sv/srdp_reply_checker.sv
tb/sv/testbench.sv
